/* rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master transaction engine.
// No dependencies; imported by the engine core and the top level.
package i2cm_pkg;

  localparam int unsigned PhaseW = 16;
  localparam int unsigned RetryW = 3;
  localparam int unsigned CfgW   = 16;

  localparam logic [PhaseW-1:0] PhaseTicksRst = 16'd50;
  localparam logic [RetryW-1:0] RetryLimitRst = 3'd3;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  // commands
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_WR1  = 2'd1;
  localparam logic [1:0] OP_WR2  = 2'd2;
  localparam logic [1:0] OP_RD   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_WR_ADDR  = 2'd1;
  localparam logic [1:0] ERR_DATA     = 2'd2;
  localparam logic [1:0] ERR_RD_ADDR  = 2'd3;

  // byte slots of a transaction
  localparam logic [1:0] BYTE_ADDR = 2'd0;
  localparam logic [1:0] BYTE_D1   = 2'd1;
  localparam logic [1:0] BYTE_D2   = 2'd2;

  // bit count at which the ACK slot runs
  localparam logic [3:0] AckBit = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SLOW,
    ST_SHIGH1,
    ST_SHIGH2,
    ST_STAIL,
    ST_PLOW,
    ST_PHIGH,
    ST_PREL
  } phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] dev_addr;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [1:0] error_code;
    logic [7:0] read_byte;
  } result_t;

endpackage

/* rtl/i2cm_engine.sv */
// Bit-phase sequencer of the I2C master: START, byte shifting, ACK, retries, STOP.
// Depends on i2cm_pkg. Advances one tick per step and returns the result of that tick.
module i2cm_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  i2cm_pkg::item_t                item_i,
  input  logic [i2cm_pkg::PhaseW-1:0]    phase_ticks_i,
  input  logic [i2cm_pkg::RetryW-1:0]    retry_limit_i,
  output i2cm_pkg::result_t              res_o
);
  import i2cm_pkg::*;

  phase_e            state_q, state_d;
  logic [PhaseW-1:0] timer_q, timer_d;
  logic [7:0]        shift_q, shift_d;
  logic [3:0]        bit_q, bit_d;
  logic [1:0]        byte_q, byte_d;
  logic [RetryW-1:0] retry_q, retry_d;
  logic [1:0]        op_q, op_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        d1_q, d1_d;
  logic [7:0]        d2_q, d2_d;
  logic              ack_q, ack_d;
  logic [1:0]        err_q, err_d;
  logic [7:0]        rbyte_q, rbyte_d;
  logic              done;

  logic [PhaseW-1:0] pt_eff;
  logic [PhaseW:0]   timer_inc;
  logic              qdone;
  logic [PhaseW-1:0] timer_adv;
  logic [RetryW-1:0] retry_inc;
  logic [7:0]        addr_byte;
  logic              recv_q, recv_d;

  assign pt_eff    = (phase_ticks_i == '0) ? PhaseW'(1) : phase_ticks_i;
  assign timer_inc = {1'b0, timer_q} + (PhaseW+1)'(1);
  assign qdone     = timer_inc >= {1'b0, pt_eff};
  assign timer_adv = qdone ? '0 : timer_inc[PhaseW-1:0];
  assign retry_inc = retry_q + RetryW'(1);
  assign addr_byte = (op_q == OP_RD) ? addr_q + 8'd1 : addr_q;
  assign recv_q    = (op_q == OP_RD) && (byte_q == BYTE_D1);
  assign recv_d    = (op_d == OP_RD) && (byte_d == BYTE_D1);

  // next state
  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    retry_d = retry_q;
    op_d    = op_q;
    addr_d  = addr_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    ack_d   = ack_q;
    err_d   = err_q;
    rbyte_d = rbyte_q;
    done    = 1'b0;
    if (step_i) begin
      unique case (state_q)
        ST_IDLE: begin
          if (item_i.op != OP_NONE) begin
            op_d    = item_i.op;
            addr_d  = item_i.dev_addr;
            d1_d    = item_i.data_first;
            d2_d    = item_i.data_second;
            err_d   = (item_i.op == OP_RD) ? ERR_RD_ADDR : ERR_WR_ADDR;
            if (item_i.op == OP_RD) begin
              rbyte_d = '0;
            end
            retry_d = '0;
            byte_d  = BYTE_ADDR;
            bit_d   = '0;
            state_d = ST_START;
            timer_d = '0;
          end
        end
        ST_START: begin
          timer_d = timer_adv;
          if (qdone) begin
            byte_d  = BYTE_ADDR;
            shift_d = addr_byte;
            bit_d   = '0;
            state_d = ST_SLOW;
          end
        end
        ST_SLOW: begin
          timer_d = timer_adv;
          if (qdone) begin
            state_d = ST_SHIGH1;
          end
        end
        ST_SHIGH1: begin
          // restart the phase while a slave stretches SCL
          if (!item_i.scl_in) begin
            timer_d = '0;
          end else begin
            timer_d = timer_adv;
            if (qdone) begin
              if (bit_q >= AckBit) begin
                if (!recv_q) begin
                  ack_d = ~item_i.sda_in;
                end
              end else if (recv_q) begin
                shift_d = {shift_q[6:0], item_i.sda_in};
              end
              state_d = ST_SHIGH2;
            end
          end
        end
        ST_SHIGH2: begin
          timer_d = timer_adv;
          if (qdone) begin
            state_d = ST_STAIL;
          end
        end
        ST_STAIL: begin
          timer_d = timer_adv;
          if (qdone) begin
            if (bit_q < AckBit) begin
              if (!recv_q) begin
                shift_d = {shift_q[6:0], 1'b0};
              end
              bit_d   = bit_q + 4'd1;
              state_d = ST_SLOW;
            end else if (byte_q == BYTE_ADDR) begin
              if (ack_q) begin
                err_d   = (op_q == OP_RD) ? ERR_OK : ERR_DATA;
                byte_d  = BYTE_D1;
                shift_d = (op_q == OP_RD) ? 8'd0 : d1_q;
                bit_d   = '0;
                state_d = ST_SLOW;
              end else begin
                retry_d = retry_inc;
                if (retry_inc >= retry_limit_i) begin
                  state_d = ST_PLOW;
                end else begin
                  shift_d = addr_byte;
                  bit_d   = '0;
                  state_d = ST_SLOW;
                end
              end
            end else if (recv_q) begin
              rbyte_d = shift_q;
              state_d = ST_PLOW;
            end else if (!ack_q) begin
              state_d = ST_PLOW;
            end else if (op_q == OP_WR2 && byte_q == BYTE_D1) begin
              byte_d  = BYTE_D2;
              shift_d = d2_q;
              bit_d   = '0;
              state_d = ST_SLOW;
            end else begin
              err_d   = ERR_OK;
              state_d = ST_PLOW;
            end
          end
        end
        ST_PLOW: begin
          timer_d = timer_adv;
          if (qdone) begin
            state_d = ST_PHIGH;
          end
        end
        ST_PHIGH: begin
          if (!item_i.scl_in) begin
            timer_d = '0;
          end else begin
            timer_d = timer_adv;
            if (qdone) begin
              state_d = ST_PREL;
            end
          end
        end
        ST_PREL: begin
          timer_d = timer_adv;
          if (qdone) begin
            state_d = ST_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
          state_d = ST_IDLE;
          timer_d = '0;
        end
      endcase
    end
  end

  // pin drive and status for the state after this tick
  always_comb begin
    res_o = '0;
    unique case (state_d)
      ST_START: res_o.sda_low = 1'b1;
      ST_SLOW, ST_SHIGH1, ST_SHIGH2, ST_STAIL: begin
        res_o.scl_low = (state_d == ST_SLOW) || (state_d == ST_STAIL);
        res_o.sda_low = (bit_d < AckBit) && !recv_d && !shift_d[7];
      end
      ST_PLOW: begin
        res_o.scl_low = 1'b1;
        res_o.sda_low = 1'b1;
      end
      ST_PHIGH: res_o.sda_low = 1'b1;
      default: ;
    endcase
    res_o.busy_res   = state_d != ST_IDLE;
    res_o.done_res   = done;
    res_o.ack_ok     = ack_d;
    res_o.error_code = err_d;
    res_o.read_byte  = rbyte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      timer_q <= '0;
      shift_q <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      retry_q <= '0;
      op_q    <= '0;
      addr_q  <= '0;
      d1_q    <= '0;
      d2_q    <= '0;
      ack_q   <= 1'b0;
      err_q   <= '0;
      rbyte_q <= '0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      retry_q <= retry_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      ack_q   <= ack_d;
      err_q   <= err_d;
      rbyte_q <= rbyte_d;
    end
  end

endmodule

/* rtl/i2c_master_transaction_engine_top.sv */
// Top level of the I2C master transaction engine: stream ports, config registers,
// result register. Depends on i2cm_pkg and i2cm_engine.
//
// Each input transfer is one clock tick of the I2C engine carrying the sampled
// SCL/SDA levels and an optional command; each one produces exactly one result
// transfer with the pin drives and status after that tick. The engine sequencer
// updates its state in the cycle the transfer is taken and the result lands in
// a single output register, so the block takes one transfer per clock cycle for
// as long as the result side keeps taking them; the output register is the only
// thing that can hold the input side back. Bus timing follows phase_ticks counted
// in transfers, not clock cycles. No clearing pass after reset.
module i2c_master_transaction_engine_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // op[1:0], dev_addr[9:2], data_first[17:10], data_second[25:18],
  // scl_in[26], sda_in[27], zero fill[31:28]
  input  logic [31:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // scl_low[0], sda_low[1], busy_res[2], done_res[3], ack_ok[4],
  // error_code[6:5], read_byte[14:7], zero fill[15]
  output logic [15:0]                m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [i2cm_pkg::CfgW-1:0]  cfg_wdata_i
);
  import i2cm_pkg::*;

  logic [PhaseW-1:0] phase_ticks_q;
  logic [RetryW-1:0] retry_limit_q;
  logic              valid_q;
  logic [15:0]       tdata_q;
  logic              in_fire;
  item_t             item;
  result_t           res;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign item.op          = s_axis_tdata[1:0];
  assign item.dev_addr    = s_axis_tdata[9:2];
  assign item.data_first  = s_axis_tdata[17:10];
  assign item.data_second = s_axis_tdata[25:18];
  assign item.scl_in      = s_axis_tdata[26];
  assign item.sda_in      = s_axis_tdata[27];

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .item_i        (item),
    .phase_ticks_i (phase_ticks_q),
    .retry_limit_i (retry_limit_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
      retry_limit_q <= RetryLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_wdata_i[PhaseW-1:0];
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_fire) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tdata_q <= {1'b0, res.read_byte, res.error_code, res.ack_ok, res.done_res,
                  res.busy_res, res.sda_low, res.scl_low};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;

endmodule

/* rtl/i2cm_checker.sv */
// Port-level checks for the I2C master transaction engine top level.
// No package dependency; bound to i2c_master_transaction_engine_top below.
module i2cm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a full, stalled result register blocks the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result register is full");

  // STOP completion leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done reported while still busy");

  // an idle engine releases both lines
  a_idle_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("pin driven low while idle");

endmodule

bind i2c_master_transaction_engine_top i2cm_port_checker u_i2cm_checker (.*);
